FILE: design/jhc_pkg.sv
// Shared types and constants for the joint histogram counter.
// No dependencies.
`timescale 1ns / 1ps
package jhc_pkg;

  localparam int NUM_VALUES = 4;

  // beat action codes
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // register indexes, byte address is 4x the index
  localparam logic [2:0] REG_DOMAIN  = 3'd0;
  localparam logic [2:0] REG_COLUMNS = 3'd1;
  localparam logic [2:0] REG_STRIDE0 = 3'd2;
  localparam logic [2:0] REG_STRIDE1 = 3'd3;
  localparam logic [2:0] REG_STRIDE2 = 3'd4;
  localparam logic [2:0] REG_STRIDE3 = 3'd5;

  typedef logic [31:0] word_t;
  typedef word_t [NUM_VALUES-1:0] word_vec_t;

  // one classified beat passed from the front to the back
  typedef struct packed {
    logic  is_read;
    logic  flag;
    logic  mem_ok;
    word_t idx;
  } job_t;

endpackage

FILE: design/jhc_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module jhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/jhc_front.sv
// Front end: accepts input beats, forms the bin index with one shared multiplier
// and classifies the beat. Depends on jhc_pkg.
`timescale 1ns / 1ps
module jhc_front import jhc_pkg::*; #(
  parameter int BINS    = 65536,
  parameter int COLUMNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        clearing,
  input  logic [16:0] domain_size,
  input  logic [2:0]  columns_in_use,
  input  word_vec_t   strides,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] value_col0,
  input  logic [31:0] value_col1,
  input  logic [31:0] value_col2,
  input  logic [31:0] value_col3,
  input  logic [15:0] read_bin,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [2:0] COL_LIMIT = (COLUMNS < NUM_VALUES) ? 3'(COLUMNS) : 3'(NUM_VALUES);
  localparam word_t BINS_W = word_t'(BINS);

  logic [1:0]  state;
  logic [2:0]  col;
  word_t       prod;
  logic        prod_vld;
  word_t       acc;
  logic        act;
  word_vec_t   vals;
  logic [15:0] rbin;

  logic [2:0]  ncol;
  word_t       dom_w;
  word_t       eff_dom;
  word_t       val_sel;
  word_t       stride_sel;
  word_t       mul_lo;
  word_t       read_idx;

  assign ncol       = (columns_in_use > COL_LIMIT) ? COL_LIMIT : columns_in_use;
  assign dom_w      = {15'b0, domain_size};
  assign eff_dom    = (dom_w > BINS_W) ? BINS_W : dom_w;
  assign val_sel    = vals[col[1:0]];
  assign stride_sel = strides[col[1:0]];
  assign mul_lo     = val_sel * stride_sel;
  assign read_idx   = {16'b0, rbin};

  assign in_ready  = (state == F_IDLE) && !clearing;
  assign job_valid = (state == F_PUSH);

  always_comb begin
    job.is_read = act;
    if (act == ACT_READ) begin
      job.idx    = read_idx;
      job.flag   = (read_idx >= eff_dom);
      job.mem_ok = (read_idx < BINS_W);
    end else begin
      job.idx    = acc;
      job.flag   = (acc >= eff_dom);
      job.mem_ok = (acc < eff_dom);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      prod_vld <= 1'b0;
      col      <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            act      <= action;
            vals     <= {value_col3, value_col2, value_col1, value_col0};
            rbin     <= read_bin;
            col      <= '0;
            prod_vld <= 1'b0;
            acc      <= '0;
            state    <= (action == ACT_READ) ? F_PUSH : F_CALC;
          end
        end
        F_CALC: begin
          if (prod_vld) begin
            acc <= acc + prod;
          end
          if (col < ncol) begin
            prod     <= mul_lo;
            prod_vld <= 1'b1;
            col      <= col + 3'd1;
          end else begin
            prod_vld <= 1'b0;
          end
          if ((col >= ncol) && !prod_vld) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/jhc_queue.sv
// Two-entry queue of classified beats between front and back.
// Depends on jhc_pkg.
`timescale 1ns / 1ps
module jhc_queue import jhc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  job_t          q [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   cnt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt != (PW+1)'(DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = q[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

FILE: design/jhc_back.sv
// Back end: clears the bin store after reset, then does read-modify-write of bin
// counts and drives the result register. Depends on jhc_pkg and jhc_ram.
`timescale 1ns / 1ps
module jhc_back import jhc_pkg::*; #(
  parameter int BINS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  output logic        clearing,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] bin_index,
  output logic        out_of_range,
  output logic [31:0] bin_count,
  output logic [31:0] rows_counted
);

  localparam int AW = $clog2(BINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BINS - 1);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_UPD   = 2'd2;

  logic [1:0]    state;
  logic [AW-1:0] clr_addr;
  job_t          cur;
  word_t         row_total;

  logic          pop;
  logic          do_write;
  word_t         rdata;
  word_t         cnt_inc;
  word_t         rows_next;
  logic          we;
  logic [AW-1:0] waddr;
  word_t         wdata;

  assign clearing  = (state == B_CLEAR);
  assign job_ready = (state == B_IDLE) && (!out_valid || out_ready);
  assign pop       = job_valid && job_ready;
  assign do_write  = (state == B_UPD) && !cur.is_read && !cur.flag;
  assign cnt_inc   = rdata + 32'd1;
  assign rows_next = do_write ? (row_total + 32'd1) : row_total;
  assign we        = clearing || do_write;
  assign waddr     = clearing ? clr_addr : cur.idx[AW-1:0];
  assign wdata     = clearing ? '0 : cnt_inc;

  jhc_ram #(
    .WIDTH(32),
    .DEPTH(BINS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (pop),
    .raddr(job.idx[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      row_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            cur   <= job;
            state <= B_UPD;
          end
        end
        B_UPD: begin
          row_total    <= rows_next;
          out_valid    <= 1'b1;
          bin_index    <= cur.idx;
          out_of_range <= cur.flag;
          rows_counted <= rows_next;
          if (cur.is_read) begin
            bin_count <= cur.mem_ok ? rdata : '0;
          end else begin
            bin_count <= cur.flag ? '0 : cnt_inc;
          end
          state <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/joint_histogram_counter.sv
// Top level of the joint histogram counter: APB register file, front, queue, back.
// Depends on jhc_pkg, jhc_front, jhc_queue, jhc_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------------
//   in       | in_valid / in_ready  | action, value_col0..3, read_bin
//   out      | out_valid / out_ready| bin_index, out_of_range, bin_count, rows_counted
//   config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// A count beat occupies the front while the single shared 32x32 multiplier steps through
// n columns, n being columns_in_use capped at COLUMNS and 4; a read beat skips the
// multiplier and goes straight to the queue.
// The back takes a beat only in B_IDLE, reads its bin there and writes the count back in B_UPD.
// After reset the bin store is cleared one entry per cycle, with in_ready held low until it is done.
// The two-entry queue lets the front keep working while the result register is stalled.
`timescale 1ns / 1ps
module joint_histogram_counter import jhc_pkg::*; #(
  parameter int BINS    = 65536,
  parameter int COLUMNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] value_col0,
  input  logic [31:0] value_col1,
  input  logic [31:0] value_col2,
  input  logic [31:0] value_col3,
  input  logic [15:0] read_bin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] bin_index,
  output logic        out_of_range,
  output logic [31:0] bin_count,
  output logic [31:0] rows_counted
);

  logic [16:0] domain_size;
  logic [2:0]  columns_in_use;
  word_vec_t   strides;
  logic [2:0]  reg_sel;
  logic        cfg_wr;

  logic        clearing;
  logic        fq_valid;
  logic        fq_ready;
  job_t        fq_job;
  logic        qb_valid;
  logic        qb_ready;
  job_t        qb_job;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_size    <= 17'h10000;
      columns_in_use <= 3'd4;
      strides        <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DOMAIN:  domain_size    <= pwdata[16:0];
        REG_COLUMNS: columns_in_use <= pwdata[2:0];
        REG_STRIDE0: strides[0]     <= pwdata;
        REG_STRIDE1: strides[1]     <= pwdata;
        REG_STRIDE2: strides[2]     <= pwdata;
        REG_STRIDE3: strides[3]     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DOMAIN:  prdata = {15'b0, domain_size};
      REG_COLUMNS: prdata = {29'b0, columns_in_use};
      REG_STRIDE0: prdata = strides[0];
      REG_STRIDE1: prdata = strides[1];
      REG_STRIDE2: prdata = strides[2];
      REG_STRIDE3: prdata = strides[3];
      default:     prdata = '0;
    endcase
  end

  jhc_front #(
    .BINS   (BINS),
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .clearing      (clearing),
    .domain_size   (domain_size),
    .columns_in_use(columns_in_use),
    .strides       (strides),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .value_col0    (value_col0),
    .value_col1    (value_col1),
    .value_col2    (value_col2),
    .value_col3    (value_col3),
    .read_bin      (read_bin),
    .job_valid     (fq_valid),
    .job_ready     (fq_ready),
    .job           (fq_job)
  );

  jhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_job),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_job)
  );

  jhc_back #(
    .BINS(BINS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .job_valid   (qb_valid),
    .job_ready   (qb_ready),
    .job         (qb_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_index   (bin_index),
    .out_of_range(out_of_range),
    .bin_count   (bin_count),
    .rows_counted(rows_counted)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for joint_histogram_counter: directed table, then randomized phases.
// Depends on jhc_pkg and joint_histogram_counter; predicts every result beat in-line.
`timescale 1ns / 1ps
module testbench;
  import jhc_pkg::*;

  localparam int BINS            = 65536;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 163;
  localparam int HOLD_CYCLES     = 16;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_t;

  typedef struct packed {
    logic        action;
    word_vec_t   values;
    logic [15:0] read_bin;
  } row_beat_t;

  typedef struct packed {
    word_t bin_index;
    logic  out_of_range;
    word_t bin_count;
    word_t rows_counted;
  } hist_result_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [2:0]   reg_idx;
    word_t        reg_value;
    row_beat_t    beat;
    hist_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [31:0] value_col0 = '0;
  logic [31:0] value_col1 = '0;
  logic [31:0] value_col2 = '0;
  logic [31:0] value_col3 = '0;
  logic [15:0] read_bin = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] bin_index;
  logic        out_of_range;
  logic [31:0] bin_count;
  logic [31:0] rows_counted;

  // histogram model state and register shadow
  bit   [31:0] bin_model [0:BINS-1];
  word_t       rows_model = '0;
  logic [16:0] cfg_domain = 17'd65536;
  logic [2:0]  cfg_columns = 3'd4;
  word_t       cfg_stride [NUM_VALUES] = '{default: '0};
  logic [15:0] recent_bin = '0;

  hist_result_t pending_results [$];
  int unsigned  errors = 0;
  int unsigned  burst_left = 0;
  int unsigned  gap_max = 4;
  int unsigned  rx_tick = 0;
  int unsigned  rx_mode = 0;

  joint_histogram_counter dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .action, .value_col0, .value_col1, .value_col2, .value_col3,
    .read_bin, .out_valid, .out_ready, .bin_index, .out_of_range, .bin_count, .rows_counted
  );

  always #4 clk = ~clk;

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic hist_result_t predict_beat(input row_beat_t b);
    hist_result_t r;
    int unsigned  dom;
    int unsigned  ncol;
    r = '0;
    dom = (cfg_domain > BINS) ? BINS : 32'(cfg_domain);
    if (b.action == ACT_COUNT) begin
      ncol = (cfg_columns > NUM_VALUES) ? NUM_VALUES : 32'(cfg_columns);
      for (int c = 0; c < ncol; c++) r.bin_index += b.values[c] * cfg_stride[c];
      if (r.bin_index < dom) begin
        bin_model[r.bin_index] += 1;
        r.bin_count = bin_model[r.bin_index];
        rows_model += 1;
        recent_bin = r.bin_index[15:0];
      end else begin
        r.out_of_range = 1'b1;
      end
    end else begin
      r.bin_index = word_t'(b.read_bin);
      r.out_of_range = (r.bin_index >= dom);
      r.bin_count = bin_model[b.read_bin];
    end
    r.rows_counted = rows_model;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic act, input word_t v0, input word_t v1,
                                         input word_t v2, input word_t v3,
                                         input logic [15:0] rb);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.beat.action = act;
    r.beat.values = {v3, v2, v1, v0};
    r.beat.read_bin = rb;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input plan_row_t r, input word_t idx, input logic oor,
                                          input word_t cnt, input word_t rows);
    plan_row_t t;
    t = r;
    t.kind = ROW_TYPED;
    t.want = '{bin_index: idx, out_of_range: oor, bin_count: cnt, rows_counted: rows};
    return t;
  endfunction

  function automatic plan_row_t cfg_row(input int unsigned idx, input word_t value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx[2:0];
    r.reg_value = value;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input word_t got, input word_t want);
    if (errors < 100) $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input int unsigned idx, input word_t data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_DOMAIN) cfg_domain = data[16:0];
    else if (idx == REG_COLUMNS) cfg_columns = data[2:0];
    else if (idx >= REG_STRIDE0 && idx < REG_STRIDE0 + NUM_VALUES)
      cfg_stride[idx - REG_STRIDE0] = data;
    @(posedge clk);
  endtask

  task automatic send_beat(input row_beat_t b, input bit typed, input hist_result_t want);
    hist_result_t model;
    in_valid <= 1'b1;
    action <= b.action;
    value_col0 <= b.values[0];
    value_col1 <= b.values[1];
    value_col2 <= b.values[2];
    value_col3 <= b.values[3];
    read_bin <= b.read_bin;
    do @(posedge clk); while (!in_ready);
    model = predict_beat(b);
    pending_results.push_back(typed ? want : model);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // sender holds off until every outstanding beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  // receiver stall pattern, one of four modes, re-rolled on a tick counter
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 128 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_tick % 4 == 0);
      default: out_ready <= (rx_tick % 16 >= 12);
    endcase
  end

  always @(posedge clk) begin
    hist_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected beat, bin_index", bin_index, '0);
      end else begin
        want = pending_results.pop_front();
        if (bin_index !== want.bin_index)
          flag_mismatch("bin_index", bin_index, want.bin_index);
        if (out_of_range !== want.out_of_range)
          flag_mismatch("out_of_range", word_t'(out_of_range), word_t'(want.out_of_range));
        if (bin_count !== want.bin_count)
          flag_mismatch("bin_count", bin_count, want.bin_count);
        if (rows_counted !== want.rows_counted)
          flag_mismatch("rows_counted", rows_counted, want.rows_counted);
      end
    end
  end

  initial begin
    plan_row_t    plan [$];
    row_beat_t    b;
    hist_result_t none;
    word_t        radix;
    word_t        step;
    word_t        stride;
    logic [16:0]  dom;
    bit           wild;

    none = '0;
    // reset state: zero strides put every row in bin 0
    plan.push_back(typed_row(item_row(ACT_READ, 0, 0, 0, 0, 16'h0000), 0, 0, 0, 0));
    plan.push_back(typed_row(item_row(ACT_READ, 0, 0, 0, 0, 16'hFFFF), 32'hFFFF, 0, 0, 0));
    plan.push_back(typed_row(item_row(ACT_COUNT, '1, '1, '1, '1, 16'h0000), 0, 0, 1, 1));
    plan.push_back(cfg_row(REG_STRIDE0, 32'h1));
    plan.push_back(cfg_row(REG_STRIDE0 + 1, 32'h100));
    plan.push_back(cfg_row(REG_STRIDE0 + 2, 32'h10000));
    plan.push_back(cfg_row(REG_STRIDE0 + 3, 32'hFFFF_FFFF));
    plan.push_back(typed_row(item_row(ACT_COUNT, 32'h12, 32'h34, 0, 0, 0), 32'h3412, 0, 1, 2));
    plan.push_back(typed_row(item_row(ACT_COUNT, 0, 0, 1, 0, 0), 32'h10000, 1, 0, 2));
    plan.push_back(typed_row(item_row(ACT_COUNT, 0, 0, 0, 1, 0), 32'hFFFF_FFFF, 1, 0, 2));
    // index sum wraps back to bin 0
    plan.push_back(typed_row(item_row(ACT_COUNT, 1, 0, 0, 1, 0), 0, 0, 2, 3));
    plan.push_back(typed_row(item_row(ACT_COUNT, 32'hFFFF, 0, 0, 0, 0), 32'hFFFF, 0, 1, 4));
    plan.push_back(item_row(ACT_READ, 0, 0, 0, 0, 16'h3412));
    plan.push_back(cfg_row(REG_DOMAIN, 32'd1));
    plan.push_back(item_row(ACT_COUNT, 0, 0, 0, 0, 16'h0001));
    plan.push_back(item_row(ACT_COUNT, 1, 0, 0, 0, 0));
    plan.push_back(item_row(ACT_READ, 0, 0, 0, 0, 16'h0001));
    plan.push_back(item_row(ACT_READ, '1, '1, '1, '1, 16'h0000));
    // zero domain flags everything
    plan.push_back(cfg_row(REG_DOMAIN, 32'd0));
    plan.push_back(item_row(ACT_COUNT, 0, 0, 0, 0, 0));
    plan.push_back(item_row(ACT_READ, 0, 0, 0, 0, 16'h0000));
    plan.push_back(cfg_row(REG_DOMAIN, 32'h1_FFFF));
    plan.push_back(item_row(ACT_READ, 0, 0, 0, 0, 16'hFFFF));
    plan.push_back(item_row(ACT_COUNT, 32'hFFFF, 0, 0, 0, 0));
    plan.push_back(cfg_row(REG_COLUMNS, 32'd0));
    plan.push_back(item_row(ACT_COUNT, 5, 7, 7, 7, 0));
    // column count above four saturates
    plan.push_back(cfg_row(REG_COLUMNS, 32'd7));
    plan.push_back(item_row(ACT_COUNT, 2, 0, 0, 1, 0));
    plan.push_back(cfg_row(REG_COLUMNS, 32'd1));
    plan.push_back(item_row(ACT_COUNT, 7, 9, 0, 0, 0));
    plan.push_back(cfg_row(REG_COLUMNS, 32'd4));
    plan.push_back(cfg_row(REG_STRIDE0, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_STRIDE0 + 1, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_STRIDE0 + 2, 32'hFFFF_FFFF));
    plan.push_back(item_row(ACT_COUNT, '1, '1, '1, '1, 0));
    plan.push_back(item_row(ACT_READ, 0, 0, 0, 0, 16'h0004));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_value);
      end else begin
        send_beat(plan[i].beat, plan[i].kind == ROW_TYPED, plan[i].want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      wild = ($urandom_range(0, 9) < 3);
      radix = $urandom_range(2, 16);
      case ($urandom_range(0, 4))
        0: dom = 17'($urandom_range(1, 64));
        1: dom = 17'($urandom_range(1, 65536));
        2: dom = 17'd65536;
        3: dom = 17'($urandom_range(65537, 131071));
        default: dom = 17'($urandom_range(0, 131071));
      endcase
      write_reg(REG_DOMAIN, ($urandom & ~32'h1FFFF) | dom);
      write_reg(REG_COLUMNS, ($urandom & ~32'h7) | $urandom_range(0, 7));
      step = 1;
      for (int c = 0; c < NUM_VALUES; c++) begin
        if (wild) begin
          case ($urandom_range(0, 3))
            0: stride = $urandom;
            1: stride = 32'hFFFF_FFFF;
            2: stride = $urandom_range(0, 3);
            default: stride = 32'h1 << $urandom_range(0, 31);
          endcase
        end else begin
          stride = step;
        end
        write_reg(REG_STRIDE0 + c, stride);
        step = step * radix;
      end
      gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      burst_left = 0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        b.action = ($urandom_range(0, 9) < 3) ? ACT_READ : ACT_COUNT;
        for (int c = 0; c < NUM_VALUES; c++) begin
          case ($urandom_range(0, 7))
            0: b.values[c] = $urandom;
            1: b.values[c] = ~word_t'($urandom_range(0, 3));
            default: b.values[c] = $urandom_range(0, radix - 1);
          endcase
        end
        case ($urandom_range(0, 3))
          0: b.read_bin = 16'($urandom_range(0, 65535));
          1: b.read_bin = 16'($urandom_range(0, 255));
          default: b.read_bin = recent_bin;
        endcase
        send_beat(b, 1'b0, none);
      end
    end

    drain_results();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
